// File: hw/rtl/atsm_pkg.sv
// shared types, constants and the arctangent table of the tilt smoother
package atsm_pkg;

  // default parameter values
  localparam int CAL_SAMPLES_DEF  = 50;
  localparam int CORDIC_STEPS_DEF = 16;

  // angle format: degrees with ANGLE_FRAC_BITS fraction bits, cordic angle at 2^-ZFRAC degree
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ZFRAC           = 20;
  localparam int ANGLE_SHIFT     = ZFRAC - ANGLE_FRAC_BITS;
  localparam int ZHALF           = 1 << (ANGLE_SHIFT - 1);
  localparam int Z180            = 180 << ZFRAC;
  localparam int FULL_ANGLE      = 180 << ANGLE_FRAC_BITS;

  // sequencing lengths
  localparam int STEP_W     = 5;
  localparam int SQRT_STEPS = 16;

  // offset averaging by reciprocal multiply: magnitudes below 2^MAG_W, window of at most 63
  localparam int MAG_W       = 23;
  localparam int RECIP_SHIFT = MAG_W + 6;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  // configuration register indexes and reset values
  localparam logic [0:0] REG_ALPHA     = 1'b0;
  localparam logic [0:0] REG_LEVEL_THR = 1'b1;
  localparam logic [15:0] ALPHA_RST    = 16'd9830;
  localparam logic [15:0] THR_RST      = 16'd256;

  // commands from the controller to the datapath
  typedef struct packed {
    logic              load;
    logic              sq_y;
    logic              sq_z;
    logic              sqrt_step;
    logic              cord_init;
    logic              cord_step;
    logic              cord_end;
    logic              update;
    logic              sub;
    logic              mul_lo;
    logic              mul_hi;
    logic              div_last;
    logic              out_load;
    logic              axis;
    logic [STEP_W-1:0] step;
  } atsm_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic win;
    logic complete;
  } atsm_sts_t;

  // atan(2^-i) in 2^-20 degree
  function automatic logic signed [29:0] atsm_atan(input logic [STEP_W-1:0] i);
    logic signed [29:0] v;
    case (i)
      5'd0:    v = 30'sd47185920;
      5'd1:    v = 30'sd27855475;
      5'd2:    v = 30'sd14718068;
      5'd3:    v = 30'sd7471121;
      5'd4:    v = 30'sd3750058;
      5'd5:    v = 30'sd1876857;
      5'd6:    v = 30'sd938658;
      5'd7:    v = 30'sd469357;
      5'd8:    v = 30'sd234682;
      5'd9:    v = 30'sd117342;
      5'd10:   v = 30'sd58671;
      5'd11:   v = 30'sd29335;
      5'd12:   v = 30'sd14668;
      5'd13:   v = 30'sd7334;
      5'd14:   v = 30'sd3667;
      5'd15:   v = 30'sd1833;
      5'd16:   v = 30'sd917;
      5'd17:   v = 30'sd458;
      5'd18:   v = 30'sd229;
      5'd19:   v = 30'sd115;
      5'd20:   v = 30'sd57;
      5'd21:   v = 30'sd29;
      5'd22:   v = 30'sd14;
      5'd23:   v = 30'sd7;
      default: v = 30'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/atsm_ctrl.sv
// sequencing state machine of the tilt smoother
module atsm_ctrl #(
  parameter int CORDIC_STEPS = atsm_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  atsm_pkg::atsm_sts_t sts_i,
  output atsm_pkg::atsm_cmd_t cmd_o
);
  import atsm_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_SQY   = 12'b0000_0000_0010,
    S_SQZ   = 12'b0000_0000_0100,
    S_SQRT  = 12'b0000_0000_1000,
    S_CINIT = 12'b0000_0001_0000,
    S_CSTEP = 12'b0000_0010_0000,
    S_CEND  = 12'b0000_0100_0000,
    S_UPD   = 12'b0000_1000_0000,
    S_SUB   = 12'b0001_0000_0000,
    S_MLO   = 12'b0010_0000_0000,
    S_MHI   = 12'b0100_0000_0000,
    S_DIV   = 12'b1000_0000_0000
  } ctrl_state_e;

  localparam logic [STEP_W-1:0] CORD_LAST = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);

  ctrl_state_e       state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              phase_q, phase_d;
  logic              out_valid_q, out_valid_d;
  logic              fin_q, fin_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    cmd_o.axis  = phase_q;
    cmd_o.step  = cnt_q;

    // finished item waits here until the output register is free
    if (fin_q) begin
      if (!out_valid_q || out_ready_i) begin
        cmd_o.out_load = 1'b1;
        out_valid_d    = 1'b1;
        fin_d          = 1'b0;
        state_d        = S_IDLE;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = S_SQY;
          end
        end
        S_SQY: begin
          cmd_o.sq_y = 1'b1;
          state_d    = S_SQZ;
        end
        S_SQZ: begin
          cmd_o.sq_z = 1'b1;
          cnt_d      = '0;
          state_d    = S_SQRT;
        end
        S_SQRT: begin
          cmd_o.sqrt_step = 1'b1;
          if (cnt_q == SQRT_LAST) begin
            cnt_d   = '0;
            phase_d = 1'b0;
            state_d = S_CINIT;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        S_CINIT: begin
          cmd_o.cord_init = 1'b1;
          cnt_d           = '0;
          state_d         = S_CSTEP;
        end
        S_CSTEP: begin
          cmd_o.cord_step = 1'b1;
          if (cnt_q == CORD_LAST) begin
            state_d = S_CEND;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        S_CEND: begin
          cmd_o.cord_end = 1'b1;
          if (!phase_q) begin
            phase_d = 1'b1;
            state_d = S_CINIT;
          end else begin
            state_d = S_UPD;
          end
        end
        S_UPD: begin
          cmd_o.update = 1'b1;
          phase_d      = 1'b0;
          cnt_d        = '0;
          if (sts_i.win) begin
            if (sts_i.complete) begin
              state_d = S_DIV;
            end else begin
              fin_d = 1'b1;
            end
          end else begin
            state_d = S_SUB;
          end
        end
        S_SUB: begin
          cmd_o.sub = 1'b1;
          state_d   = S_MLO;
        end
        S_MLO: begin
          cmd_o.mul_lo = 1'b1;
          state_d      = S_MHI;
        end
        S_MHI: begin
          cmd_o.mul_hi = 1'b1;
          if (!phase_q) begin
            phase_d = 1'b1;
            state_d = S_SUB;
          end else begin
            fin_d = 1'b1;
          end
        end
        S_DIV: begin
          cmd_o.div_last = 1'b1;
          fin_d          = 1'b1;
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      fin_q       <= fin_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && !fin_q;
  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/atsm_dp.sv
// datapath: square root, shared cordic, calibration, smoothing and output register
module atsm_dp #(
  parameter int CAL_SAMPLES = atsm_pkg::CAL_SAMPLES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                command_i,
  input  logic signed [15:0]  accel_x_i,
  input  logic signed [15:0]  accel_y_i,
  input  logic signed [15:0]  accel_z_i,
  input  atsm_pkg::atsm_cmd_t cmd_i,
  output atsm_pkg::atsm_sts_t sts_o,
  output logic signed [17:0]  pitch_angle_o,
  output logic signed [17:0]  roll_angle_o,
  output logic                is_level_o,
  output logic                calibrating_o,
  output logic                calibration_done_o,
  output logic signed [16:0]  pitch_offset_now_o,
  output logic signed [16:0]  roll_offset_now_o
);
  import atsm_pkg::*;

  localparam int CW = $clog2(CAL_SAMPLES + 1);
  localparam logic [CW-1:0]      CAL_N    = CW'(CAL_SAMPLES);
  localparam logic [MAG_W-1:0]   MAG_HALF = MAG_W'(CAL_SAMPLES / 2);
  localparam logic [RECIP_W-1:0] RECIP    =
    RECIP_W'(((1 << RECIP_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES);
  localparam logic signed [29:0] Z_HALF   = 30'(ZHALF);
  localparam logic signed [29:0] Z_180    = 30'(Z180);
  localparam logic signed [29:0] LIM_ROLL = 30'(FULL_ANGLE);
  localparam logic signed [29:0] LIM_PTCH = 30'(FULL_ANGLE / 2);

  // input beat and configuration
  logic signed [15:0] ax_q, ay_q, az_q;
  logic               cmd_bit_q;
  logic [15:0]        alpha_q, thr_q;

  // square root
  logic [31:0] n_q, res_q, bit_q;
  logic [32:0] trial;
  logic        sq_ge;
  logic signed [15:0] sq_src;
  logic signed [31:0] sq_prod;

  // cordic
  logic signed [35:0] cx_q, cy_q, xs, ys;
  logic signed [29:0] cz_q, rz, rz_cl, lim;
  logic               zero_q;
  logic signed [17:0] yin, xin, ya, xa;
  logic signed [16:0] raw_p_q, raw_r_q;

  // calibration and smoothing state
  logic signed [33:0] acc_p_q, acc_r_q, acc_sel, acc_new;
  logic signed [16:0] off_p_q, off_r_q;
  logic signed [23:0] sum_p_q, sum_r_q, psum_n, rsum_n;
  logic [CW-1:0]      cnt_q, cnt_n;
  logic               cal_active_q, win_q, done_q, start, win, complete;
  logic signed [17:0] rot;
  logic signed [35:0] d_q;
  logic [33:0]        plo_q;
  logic signed [34:0] phi;
  logic signed [53:0] total, inc;

  // offset averaging
  logic [MAG_W-1:0]         mag_p_q, mag_r_q;
  logic [MAG_W+RECIP_W-1:0] prod_p, prod_r;
  logic signed [16:0]       quo_p, quo_r;
  logic                     negp_q, negr_q;

  // outputs
  logic signed [33:0] pr_sum, rr_sum;
  logic signed [17:0] p_now, r_now;
  logic [17:0]        ap, ar;

  // square root step
  assign sq_src  = cmd_i.sq_y ? ay_q : az_q;
  assign sq_prod = sq_src * sq_src;
  assign trial   = {1'b0, res_q} + {1'b0, bit_q};
  assign sq_ge   = {1'b0, n_q} >= trial;

  // cordic operands
  always_comb begin
    if (!cmd_i.axis) begin
      yin = -{{2{ax_q[15]}}, ax_q};
      xin = {2'b00, res_q[15:0]};
    end else begin
      yin = {{2{ay_q[15]}}, ay_q};
      xin = {{2{az_q[15]}}, az_q};
    end
    xa = xin[17] ? -xin : xin;
    ya = xin[17] ? -yin : yin;
  end

  assign xs = cx_q >>> cmd_i.step;
  assign ys = cy_q >>> cmd_i.step;

  // round and clamp the cordic angle
  always_comb begin
    rz    = (cz_q + Z_HALF) >>> ANGLE_SHIFT;
    lim   = cmd_i.axis ? LIM_ROLL : LIM_PTCH;
    rz_cl = rz;
    if (rz > lim) begin
      rz_cl = lim;
    end else if (rz < -lim) begin
      rz_cl = -lim;
    end
    if (zero_q) begin
      rz_cl = '0;
    end
  end

  // calibration window bookkeeping
  assign start    = cmd_bit_q & ~cal_active_q;
  assign win      = cal_active_q | cmd_bit_q;
  assign psum_n   = (start ? 24'sd0 : sum_p_q) + 24'(raw_r_q);
  assign rsum_n   = (start ? 24'sd0 : sum_r_q) + 24'(raw_p_q);
  assign cnt_n    = (start ? '0 : cnt_q) + 1'b1;
  assign complete = cnt_n >= CAL_N;
  assign sts_o.win      = win;
  assign sts_o.complete = complete;

  // smoothing arithmetic
  assign acc_sel = cmd_i.axis ? acc_r_q : acc_p_q;
  assign rot     = cmd_i.axis ? (18'(raw_p_q) - 18'(off_r_q)) : (18'(raw_r_q) - 18'(off_p_q));
  assign phi     = $signed({1'b0, alpha_q}) * $signed(d_q[35:18]);
  assign total   = (54'(phi) <<< 18) + $signed({20'd0, plo_q}) + 54'sd32768;
  assign inc     = total >>> 16;
  assign acc_new = acc_sel + 34'(inc);

  // window average by reciprocal multiply, exact for every magnitude below 2^MAG_W
  assign prod_p = {{RECIP_W{1'b0}}, mag_p_q} * {{MAG_W{1'b0}}, RECIP};
  assign prod_r = {{RECIP_W{1'b0}}, mag_r_q} * {{MAG_W{1'b0}}, RECIP};
  assign quo_p  = prod_p[RECIP_SHIFT +: 17];
  assign quo_r  = prod_r[RECIP_SHIFT +: 17];

  // output values from the current state
  assign pr_sum = acc_p_q + 34'sd32768;
  assign rr_sum = acc_r_q + 34'sd32768;
  assign p_now  = pr_sum[33:16];
  assign r_now  = rr_sum[33:16];
  assign ap     = p_now[17] ? 18'(-p_now) : 18'(p_now);
  assign ar     = r_now[17] ? 18'(-r_now) : 18'(r_now);

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q      <= accel_x_i;
      ay_q      <= accel_y_i;
      az_q      <= accel_z_i;
      cmd_bit_q <= command_i;
    end
    if (cmd_i.sq_y) begin
      n_q <= 32'(sq_prod);
    end
    if (cmd_i.sq_z) begin
      n_q   <= n_q + 32'(sq_prod);
      res_q <= '0;
      bit_q <= 32'd1 << 30;
    end
    if (cmd_i.sqrt_step) begin
      if (sq_ge) begin
        n_q   <= n_q - trial[31:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.cord_init) begin
      cx_q   <= {{2{xa[17]}}, xa, 16'd0};
      cy_q   <= {{2{ya[17]}}, ya, 16'd0};
      cz_q   <= xin[17] ? (yin[17] ? -Z_180 : Z_180) : 30'sd0;
      zero_q <= (xin == 18'sd0) && (yin == 18'sd0);
    end
    if (cmd_i.cord_step) begin
      if (!cy_q[35]) begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + atsm_atan(cmd_i.step);
      end else begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - atsm_atan(cmd_i.step);
      end
    end
    if (cmd_i.cord_end) begin
      if (cmd_i.axis) begin
        raw_r_q <= 17'(rz_cl);
      end else begin
        raw_p_q <= 17'(rz_cl);
      end
    end
    if (cmd_i.update) begin
      win_q   <= win;
      done_q  <= win & complete;
      negp_q  <= psum_n[23];
      negr_q  <= rsum_n[23];
      mag_p_q <= (psum_n[23] ? MAG_W'(-psum_n) : MAG_W'(psum_n)) + MAG_HALF;
      mag_r_q <= (rsum_n[23] ? MAG_W'(-rsum_n) : MAG_W'(rsum_n)) + MAG_HALF;
    end
    if (cmd_i.sub) begin
      d_q <= (36'(rot) <<< 16) - 36'(acc_sel);
    end
    if (cmd_i.mul_lo) begin
      plo_q <= alpha_q * d_q[17:0];
    end
    if (cmd_i.out_load) begin
      pitch_angle_o      <= p_now;
      roll_angle_o       <= r_now;
      is_level_o         <= (ap < {2'b00, thr_q}) && (ar < {2'b00, thr_q});
      calibrating_o      <= win_q;
      calibration_done_o <= done_q;
      pitch_offset_now_o <= off_p_q;
      roll_offset_now_o  <= off_r_q;
    end
  end

  // block state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q      <= ALPHA_RST;
      thr_q        <= THR_RST;
      acc_p_q      <= '0;
      acc_r_q      <= '0;
      off_p_q      <= '0;
      off_r_q      <= '0;
      sum_p_q      <= '0;
      sum_r_q      <= '0;
      cnt_q        <= '0;
      cal_active_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ALPHA:     alpha_q <= cfg_wdata_i;
          REG_LEVEL_THR: thr_q   <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.update && win) begin
        sum_p_q <= psum_n;
        sum_r_q <= rsum_n;
        if (complete) begin
          cal_active_q <= 1'b0;
          cnt_q        <= '0;
        end else begin
          cal_active_q <= 1'b1;
          cnt_q        <= cnt_n;
        end
      end
      if (cmd_i.div_last) begin
        off_p_q <= negp_q ? -quo_p : quo_p;
        off_r_q <= negr_q ? -quo_r : quo_r;
      end
      if (cmd_i.mul_hi) begin
        if (cmd_i.axis) begin
          acc_r_q <= acc_new;
        end else begin
          acc_p_q <= acc_new;
        end
      end
    end
  end

endmodule

// File: hw/rtl/accel_tilt_smoother_unit.sv
// top level of the accelerometer tilt smoother
//
// One beat in carries a three-axis sample and a calibrate flag; one beat out
// carries smoothed pitch and roll in 1/256 degree, a level flag, window flags
// and the current offsets. Items are handled one at a time by a single
// square-root unit and one shared CORDIC run twice, once per axis. A normal
// sample then runs the smoothing update for both axes, a sample inside the
// calibration window skips it, and the sample that closes the window adds a
// divide state for the offset average done by a reciprocal multiply. A
// finished beat sits in the output register, so the next sample is taken
// while it waits; only a second finished beat waits for it.
// Configuration is to be written by the user while no item is in flight; the
// block itself does not enforce this.
module accel_tilt_smoother_unit #(
  parameter int CAL_SAMPLES  = atsm_pkg::CAL_SAMPLES_DEF,
  parameter int CORDIC_STEPS = atsm_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [17:0] pitch_angle_o,
  output logic signed [17:0] roll_angle_o,
  output logic               is_level_o,
  output logic               calibrating_o,
  output logic               calibration_done_o,
  output logic signed [16:0] pitch_offset_now_o,
  output logic signed [16:0] roll_offset_now_o
);
  import atsm_pkg::*;

  atsm_cmd_t cmd;
  atsm_sts_t sts;

  // sequencer
  atsm_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and state
  atsm_dp #(
    .CAL_SAMPLES(CAL_SAMPLES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .command_i         (command_i),
    .accel_x_i         (accel_x_i),
    .accel_y_i         (accel_y_i),
    .accel_z_i         (accel_z_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .pitch_angle_o     (pitch_angle_o),
    .roll_angle_o      (roll_angle_o),
    .is_level_o        (is_level_o),
    .calibrating_o     (calibrating_o),
    .calibration_done_o(calibration_done_o),
    .pitch_offset_now_o(pitch_offset_now_o),
    .roll_offset_now_o (roll_offset_now_o)
  );

endmodule

// File: tb/sv/accel_tilt_smoother_unit_chk.sv
// output checker of the tilt smoother: predicts each result beat and compares it
module accel_tilt_smoother_unit_chk #(
  parameter int CAL_SAMPLES  = atsm_pkg::CAL_SAMPLES_DEF,
  parameter int CORDIC_STEPS = atsm_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               command_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [17:0] pitch_angle_i,
  input  logic signed [17:0] roll_angle_i,
  input  logic               is_level_i,
  input  logic               calibrating_i,
  input  logic               calibration_done_i,
  input  logic signed [16:0] pitch_offset_now_i,
  input  logic signed [16:0] roll_offset_now_i,
  output int                 fail_cnt_o,
  output int                 pending_o
);
  import atsm_pkg::*;

  typedef struct packed {
    logic signed [17:0] pitch;
    logic signed [17:0] roll;
    logic               level;
    logic               cal;
    logic               done;
    logic signed [16:0] poff;
    logic signed [16:0] roff;
  } tilt_res_t;

  tilt_res_t tilt_q[$];

  // predictor state
  longint alpha_r, thr_r;
  longint acc_p, acc_r;
  longint off_p, off_r;
  longint sum_p, sum_r;
  int     win_cnt;
  bit     win_on;

  assign pending_o = tilt_q.size();

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - res - b;
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint lim(longint v, longint l);
    return v > l ? l : (v < -l ? -l : v);
  endfunction

  // vectoring cordic, result in 1/256 degree
  function automatic longint arctan2(longint y, longint x);
    longint z, xs, ys;
    longint tab[24] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
                        938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334,
                        3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? (longint'(180) << ZFRAC) : -(longint'(180) << ZFRAC);
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + tab[i];
      end else begin
        x = x - ys; y = y + xs; z = z - tab[i];
      end
    end
    return floor_shr(z + (longint'(1) << (ZFRAC - ANGLE_FRAC_BITS - 1)), ZFRAC - ANGLE_FRAC_BITS);
  endfunction

  function automatic longint ema(longint acc, longint rot);
    return floor_shr(alpha_r * rot * 65536 + (65536 - alpha_r) * acc + 32768, 16);
  endfunction

  function automatic longint avg_half_away(longint s);
    longint m, q;
    m = s < 0 ? -s : s;
    q = (m + CAL_SAMPLES / 2) / CAL_SAMPLES;
    return s < 0 ? -q : q;
  endfunction

  task automatic predict_tilt(bit cmd, longint ax, longint ay, longint az);
    longint mag, rp, rr, p, r, ap, ar;
    tilt_res_t e;
    mag = int_sqrt(ay * ay + az * az);
    rp = lim(arctan2(-ax, mag), FULL_ANGLE / 2);
    rr = lim(arctan2(ay, az), FULL_ANGLE);
    e.cal = 0;
    e.done = 0;
    if (cmd && !win_on) begin
      win_on = 1;
      win_cnt = 0;
      sum_p = 0;
      sum_r = 0;
    end
    if (win_on) begin
      e.cal = 1;
      sum_p += rr;
      sum_r += rp;
      win_cnt++;
      if (win_cnt >= CAL_SAMPLES) begin
        off_p = avg_half_away(sum_p);
        off_r = avg_half_away(sum_r);
        win_on = 0;
        win_cnt = 0;
        e.done = 1;
      end
    end else begin
      acc_p = ema(acc_p, rr - off_p);
      acc_r = ema(acc_r, rp - off_r);
    end
    p = floor_shr(acc_p + 32768, 16);
    r = floor_shr(acc_r + 32768, 16);
    ap = p < 0 ? -p : p;
    ar = r < 0 ? -r : r;
    e.pitch = p[17:0];
    e.roll = r[17:0];
    e.level = ap < thr_r && ar < thr_r;
    e.poff = off_p[16:0];
    e.roff = off_r[16:0];
    tilt_q.push_back(e);
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_cnt_o++;
  endtask

  // compare one result beat against the oldest prediction
  task automatic check_beat();
    tilt_res_t e;
    if (tilt_q.size() == 0) begin
      report_mismatch("result beat with nothing predicted");
      return;
    end
    e = tilt_q.pop_front();
    if (pitch_angle_i !== e.pitch)
      report_mismatch($sformatf("pitch %0d want %0d", pitch_angle_i, e.pitch));
    if (roll_angle_i !== e.roll)
      report_mismatch($sformatf("roll %0d want %0d", roll_angle_i, e.roll));
    if (is_level_i !== e.level)
      report_mismatch($sformatf("is_level %b want %b", is_level_i, e.level));
    if (calibrating_i !== e.cal)
      report_mismatch($sformatf("calibrating %b want %b", calibrating_i, e.cal));
    if (calibration_done_i !== e.done)
      report_mismatch($sformatf("calibration_done %b want %b", calibration_done_i, e.done));
    if (pitch_offset_now_i !== e.poff)
      report_mismatch($sformatf("pitch offset %0d want %0d", pitch_offset_now_i, e.poff));
    if (roll_offset_now_i !== e.roff)
      report_mismatch($sformatf("roll offset %0d want %0d", roll_offset_now_i, e.roff));
  endtask

  initial fail_cnt_o = 0;

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_r = ALPHA_RST;
      thr_r = THR_RST;
      acc_p = 0; acc_r = 0; off_p = 0; off_r = 0;
      sum_p = 0; sum_r = 0; win_cnt = 0; win_on = 0;
      tilt_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_beat();
      if (in_valid_i && in_ready_i)
        predict_tilt(command_i, accel_x_i, accel_y_i, accel_z_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_ALPHA) alpha_r = cfg_wdata_i;
        else thr_r = cfg_wdata_i;
      end
    end
  end

endmodule

// File: tb/sv/accel_tilt_smoother_unit_tb.sv
// testbench top of the tilt smoother: stimulus, register phases and verdict
module accel_tilt_smoother_unit_tb;
  import atsm_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [0:0]         cfg_idx_i = REG_ALPHA;
  logic [15:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               command_i = 1'b0;
  logic signed [15:0] accel_x_i = '0;
  logic signed [15:0] accel_y_i = '0;
  logic signed [15:0] accel_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [17:0] pitch_angle_o, roll_angle_o;
  logic               is_level_o, calibrating_o, calibration_done_o;
  logic signed [16:0] pitch_offset_now_o, roll_offset_now_o;
  int                 fail_cnt, pending;
  int                 send_idle_pct, recv_stall_pct;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  accel_tilt_smoother_unit i_dut (.*);

  accel_tilt_smoother_unit_chk i_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .command_i, .accel_x_i, .accel_y_i,
    .accel_z_i, .out_valid_i(out_valid_o), .out_ready_i,
    .pitch_angle_i(pitch_angle_o), .roll_angle_i(roll_angle_o), .is_level_i(is_level_o),
    .calibrating_i(calibrating_o), .calibration_done_i(calibration_done_o),
    .pitch_offset_now_i(pitch_offset_now_o), .roll_offset_now_i(roll_offset_now_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic put_reg(logic [0:0] idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // one sample beat; holds valid until it is taken, drops it only while idling
  task automatic send_sample(bit cmd, logic signed [15:0] x, y, z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    accel_x_i  <= x;
    accel_y_i  <= y;
    accel_z_i  <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_out();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // random sample: mostly plausible gravity, sometimes extremes, near-zero values and full range
  task automatic rand_sample(bit cmd);
    logic signed [15:0] v[3];
    int k;
    k = $urandom_range(9);
    for (int a = 0; a < 3; a++) begin
      if (k < 5) v[a] = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      else if (k < 7) v[a] = ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
      else if (k < 8) v[a] = $signed(16'($urandom_range(0, 8))) - 16'sd4;
      else v[a] = 16'($urandom);
    end
    send_sample(cmd, v[0], v[1], v[2]);
  endtask

  int         ph;
  logic [15:0] alphas[6] = '{16'd9830, 16'd0, 16'd65535, 16'd1, 16'd32768, 16'd60000};
  logic [15:0] thrs[6] = '{16'd256, 16'd0, 16'd46080, 16'd1, 16'd2560, 16'd65535};

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero vector, negative z with zero y, window start
    send_sample(0, 0, 0, 0);
    send_sample(0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(0, 16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(0, 0, 0, -16'sd100);
    send_sample(0, 0, 16'sd5, -16'sd100);
    send_sample(0, 0, -16'sd5, -16'sd100);
    send_sample(0, 16'sd100, 0, 0);
    send_sample(0, -16'sd100, 0, 0);
    send_sample(0, 0, 16'sd100, 0);
    send_sample(0, 16'shffff, 16'sh5555, 16'shaaaa);
    send_sample(1, 16'sd300, -16'sd200, 16'sd16000);
    for (int i = 0; i < CAL_SAMPLES_DEF + 2; i++)
      send_sample(i == 5, 16'($urandom_range(0, 600)) - 16'sd300,
                  16'($urandom_range(0, 600)) - 16'sd300, 16'sd16384);
    drain_out();

    // random phases with register settings and idling mixes
    for (ph = 0; ph < 6; ph++) begin
      put_reg(REG_ALPHA, alphas[ph]);
      put_reg(REG_LEVEL_THR, thrs[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int i = 0; i < 73; i++) rand_sample($urandom_range(29) == 0);
      drain_out();
    end

    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
